FILE: design/rps_pkg.sv
// Shared types and constants for the region page splitter.
// No dependencies; imported by rps_front, rps_back and region_page_splitter.
package rps_pkg;

    localparam int unsigned ADDR_W     = 48;
    localparam int unsigned ATTR_W     = 16;
    localparam int unsigned CNT_W      = 6;
    localparam int unsigned CODE_W     = 3;
    localparam int unsigned STAT_W     = 2;
    localparam int unsigned NUM_SIZES  = 8;
    localparam int unsigned IN_DATA_W  = 168;
    localparam int unsigned OUT_DATA_W = 128;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_NO_ENTRY  = 2'd1,
        ST_MISALIGN  = 2'd2
    } t_status;

    // log2 of each page size, indexed by page size code
    typedef int unsigned t_shift_tab [NUM_SIZES];
    localparam t_shift_tab PAGE_SHIFT = '{12, 14, 16, 21, 25, 29, 30, 34};

    typedef struct packed {
        logic [ADDR_W-1:0] virt;
        logic [ADDR_W-1:0] phys;
        logic [ADDR_W-1:0] length;
        logic [ATTR_W-1:0] attr;
        logic [CNT_W-1:0]  avail;
    } t_region;

    // descriptor handoff between front and back
    typedef struct packed {
        logic    valid;
        t_region region;
    } t_desc;

endpackage

FILE: design/rps_front.sv
// Front end: accepts region items, saturates the entry budget and queues them.
// Depends on rps_pkg.
module rps_front #(
    parameter int MAX_ENTRIES = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [rps_pkg::IN_DATA_W-1:0]     i_s_tdata,
    output rps_pkg::t_desc                    o_desc,
    input  logic                              i_pop
);
    import rps_pkg::*;

    localparam int DEPTH = 2;

    t_region             r_mem [DEPTH];
    logic                r_wr_ptr;
    logic                r_rd_ptr;
    logic [1:0]          r_count;
    t_region             n_region;
    logic                w_push;
    logic                w_pop;

    always_comb begin
        n_region.virt   = i_s_tdata[47:0];
        n_region.phys   = i_s_tdata[95:48];
        n_region.length = i_s_tdata[143:96];
        n_region.attr   = i_s_tdata[159:144];
        // clamp the budget to what the block may ever produce
        if (i_s_tdata[165:160] > CNT_W'(MAX_ENTRIES)) begin
            n_region.avail = CNT_W'(MAX_ENTRIES);
        end else begin
            n_region.avail = i_s_tdata[165:160];
        end
    end

    assign o_s_tready = (r_count != 2'(DEPTH));
    assign w_push     = i_s_tvalid && o_s_tready;
    assign w_pop      = i_pop && (r_count != 2'd0);

    assign o_desc.valid  = (r_count != 2'd0);
    assign o_desc.region = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= n_region;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + 2'(w_push) - 2'(w_pop);
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'(DEPTH))
        else $error("queue fill count above depth");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0) |=> (r_count <= 2'd1))
        else $error("queue count moved by more than one from empty");

endmodule

FILE: design/rps_back.sv
// Back end: splits one queued region into pages, one page per cycle while the
// output is not stalled, and drives the registered result stream. Depends on rps_pkg.
module rps_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  rps_pkg::t_desc                    i_desc,
    output logic                              o_pop,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [rps_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    output logic                              o_m_tuser,
    output logic                              o_m_tlast
);
    import rps_pkg::*;

    // working region
    logic                 r_busy;
    logic [ADDR_W-1:0]    r_va;
    logic [ADDR_W-1:0]    r_pa;
    logic [ADDR_W-1:0]    r_remain;
    logic [ATTR_W-1:0]    r_attr;
    logic [CNT_W-1:0]     r_avail;
    logic [CNT_W-1:0]     r_count;

    // output register
    logic                 r_out_valid;
    logic [ADDR_W-1:0]    r_out_va;
    logic [ADDR_W-1:0]    r_out_pa;
    logic [CODE_W-1:0]    r_out_code;
    logic [ATTR_W-1:0]    r_out_attr;
    logic [CNT_W-1:0]     r_out_num;
    logic                 r_out_is_stat;
    t_status              r_out_stat;

    logic                 w_slot_free;
    logic                 w_step;
    logic [NUM_SIZES-1:0] w_fits;
    logic                 w_found;
    logic [CODE_W-1:0]    w_code;
    logic [ADDR_W-1:0]    w_size;
    logic                 w_empty;
    logic                 w_full;

    assign w_slot_free = !r_out_valid || i_m_tready;
    assign w_step      = r_busy && w_slot_free;
    assign o_pop       = !r_busy && i_desc.valid;
    assign w_empty     = (r_remain == '0);
    assign w_full      = (r_count == r_avail);

    // candidate page sizes: both addresses aligned and length covers the page
    always_comb begin
        logic [ADDR_W-1:0] low_mask;
        for (int s = 0; s < NUM_SIZES; s++) begin
            low_mask  = (ADDR_W'(1) << PAGE_SHIFT[s]) - ADDR_W'(1);
            w_fits[s] = ((r_va & low_mask) == '0) && ((r_pa & low_mask) == '0)
                        && ((r_remain & ~low_mask) != '0);
        end
    end

    // largest fitting size wins
    always_comb begin
        w_found = 1'b0;
        w_code  = '0;
        for (int s = 0; s < NUM_SIZES; s++) begin
            if (w_fits[s]) begin
                w_found = 1'b1;
                w_code  = CODE_W'(s);
            end
        end
        w_size = ADDR_W'(1) << PAGE_SHIFT[w_code];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_step) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                r_busy   <= 1'b1;
                r_va     <= i_desc.region.virt;
                r_pa     <= i_desc.region.phys;
                r_remain <= i_desc.region.length;
                r_attr   <= i_desc.region.attr;
                r_avail  <= i_desc.region.avail;
                r_count  <= '0;
            end else if (w_step) begin
                r_out_va    <= r_va;
                r_out_pa    <= r_pa;
                r_out_num   <= r_count;
                if (!w_empty && !w_full && w_found) begin
                    // emit a page and advance
                    r_out_code    <= w_code;
                    r_out_attr    <= r_attr;
                    r_out_is_stat <= 1'b0;
                    r_out_stat    <= ST_OK;
                    r_va          <= r_va + w_size;
                    r_pa          <= r_pa + w_size;
                    r_remain      <= r_remain - w_size;
                    r_count       <= r_count + CNT_W'(1);
                end else begin
                    // close the region with its status item
                    r_out_code    <= '0;
                    r_out_attr    <= '0;
                    r_out_is_stat <= 1'b1;
                    if (w_empty) begin
                        r_out_stat <= ST_OK;
                    end else if (w_full) begin
                        r_out_stat <= ST_NO_ENTRY;
                    end else begin
                        r_out_stat <= ST_MISALIGN;
                    end
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_is_stat;
    assign o_m_tlast  = r_out_is_stat;
    assign o_m_tdata  = {5'b0, r_out_stat, r_out_num, r_out_attr, r_out_code,
                         r_out_pa, r_out_va};

    a_count_in_budget: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_count <= r_avail))
        else $error("page count ran past the entry budget");

    a_status_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && (w_empty || w_full || !w_found)) |=> !r_busy)
        else $error("region still active after its status item");

endmodule

FILE: design/region_page_splitter.sv
// Region page splitter: the back end loads an accepted item from the queue, then emits
// one result per cycle while the output is not stalled, so a region occupies it for
// a load, one step per page and a status item, in that order.
// Absent back-pressure, the back end's one-page-per-cycle loop sets throughput;
// a 2-entry queue lets the front accept while a region is being split.
// Reset (synchronous, active low) empties the queue and the output register.
module region_page_splitter #(
    parameter int MAX_ENTRIES = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // slave side
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // tdata: region_virt[47:0], region_phys[95:48], region_length[143:96],
    //        attributes[159:144], entries_available[165:160], zero pad
    input  logic [rps_pkg::IN_DATA_W-1:0]     i_s_tdata,
    // master side
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // tdata: page_virt[47:0], page_phys[95:48], page_size_code[98:96],
    //        page_attributes[114:99], entry_number[120:115], status[122:121],
    //        zero pad
    output logic [rps_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    // tuser: is_status
    output logic                              o_m_tuser,
    // tlast: last result of the region
    output logic                              o_m_tlast
);
    import rps_pkg::*;

    t_desc w_desc;
    logic  w_pop;

    // accept, clamp the entry budget, and queue region descriptors
    rps_front #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_desc     (w_desc),
        .i_pop      (w_pop)
    );

    // split the head region into pages and drive the result stream
    rps_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_desc     (w_desc),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule
